/* sv/h_bridge_pwm_command_unit_defines.svh */
// Assertion macros shared by the checker of the H-bridge command unit.
`ifndef H_BRIDGE_PWM_COMMAND_UNIT_DEFINES_SVH
`define H_BRIDGE_PWM_COMMAND_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBPWM_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBPWM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/hbpwm_pkg.sv */
`timescale 1ns / 1ps

package hbpwm_pkg;

    localparam int OP_W      = 3;
    localparam int DUTY_IN_W = 16;
    localparam int DIR_IN_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int PERIOD_W  = 16;
    localparam int DUTY_W    = 14;

    localparam logic [DUTY_W-1:0]   DUTY_FULL    = 14'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd999;

    // floor(x / 10000) is computed as floor((x >> 4) / 625), the second step
    // as a multiplication by a rounded-up reciprocal of 625 and a shift.
    localparam int PROD_W      = PERIOD_W + DUTY_W;
    localparam int PRE_SHIFT   = 4;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 36;
    localparam logic [RECIP_W-1:0] RECIP_625 = 27'd109951163;
    localparam int MUL_W       = PROD_W - PRE_SHIFT + RECIP_W;
    localparam int QUOT_W      = MUL_W - RECIP_SHIFT;

    typedef enum logic [OP_W-1:0] {
        OP_INIT     = 3'd0,
        OP_ENABLE   = 3'd1,
        OP_DISABLE  = 3'd2,
        OP_SET_DUTY = 3'd3,
        OP_SET_DIR  = 3'd4,
        OP_BRAKE    = 3'd5,
        OP_READ     = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOT_INIT = 2'd1,
        ST_BAD_ARG  = 2'd2
    } status_t;

    typedef enum logic [DIR_IN_W-1:0] {
        DIR_FORWARD = 2'd0,
        DIR_REVERSE = 2'd1
    } dir_t;

    typedef enum logic [1:0] {
        CMP_HOLD  = 2'd0,
        CMP_ZERO  = 2'd1,
        CMP_APPLY = 2'd2
    } cmp_act_t;

    typedef enum logic {
        CFG_PWM1_PERIOD = 1'b0,
        CFG_PWM2_PERIOD = 1'b1
    } cfg_index_t;

endpackage

/* sv/hbpwm_if.sv */
`timescale 1ns / 1ps

interface hbpwm_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [hbpwm_pkg::OP_W-1:0]          op;
    logic signed [hbpwm_pkg::DUTY_IN_W-1:0] duty_request;
    logic [hbpwm_pkg::DIR_IN_W-1:0]      dir_request;
    logic                                diag_level;

    modport source (output valid, output op, output duty_request, output dir_request,
                     output diag_level, input ready);
    modport sink (input valid, input op, input duty_request, input dir_request,
                   input diag_level, output ready);
endinterface

interface hbpwm_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [hbpwm_pkg::STATUS_W-1:0]     status;
    logic [hbpwm_pkg::PERIOD_W-1:0]     pwm1_compare;
    logic [hbpwm_pkg::PERIOD_W-1:0]     pwm2_compare;
    logic                               enable_level;
    logic                               enable_bar_level;
    logic                               fault;
    logic                               is_enabled;
    logic [hbpwm_pkg::DUTY_W-1:0]       duty_now;
    logic                               dir_now;

    modport source (output valid, output status, output pwm1_compare, output pwm2_compare,
                     output enable_level, output enable_bar_level, output fault,
                     output is_enabled, output duty_now, output dir_now, input ready);
    modport sink (input valid, input status, input pwm1_compare, input pwm2_compare,
                   input enable_level, input enable_bar_level, input fault,
                   input is_enabled, input duty_now, input dir_now, output ready);
endinterface

interface hbpwm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic                           index;
    logic [hbpwm_pkg::PERIOD_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/h_bridge_pwm_command_unit.sv */
`timescale 1ns / 1ps
// H-bridge sign-magnitude PWM command unit.
// The cmd channel carries one driver command per item (init, enable, disable,
// set duty, set direction, brake, read status). For every command item the
// rsp channel returns exactly one item with the command status, both PWM
// compare values, the EN/ENB levels, fault, enable state, duty and direction.
// The cfg channel writes the two PWM periods; index 0 is the first timer and
// index 1 the second. It is always ready and should be used only while no
// command is in flight. A new period takes effect the next time a compare is
// computed.
// A command passes an input register, a stage that updates the driver state
// and forms period times duty, and a stage that divides by 10000 through a
// reciprocal multiplication into the output register, with one item accepted
// per cycle while rsp.ready is high. The two multipliers set this depth.
// Reset turns the driver off (EN low, ENB high, compares zero), clears all
// flags and sets both periods to 999. When the receiver stalls, the response
// holds and the stages behind it fill up before cmd.ready falls.
module h_bridge_pwm_command_unit (
    input  logic               clk,
    input  logic               rst_n,
    hbpwm_cmd_if.sink          cmd,
    hbpwm_rsp_if.source        rsp,
    hbpwm_cfg_if.sink          cfg
);

    logic [hbpwm_pkg::PERIOD_W-1:0] pwm1_period_reg;
    logic [hbpwm_pkg::PERIOD_W-1:0] pwm2_period_reg;

    logic                          ready_flag_reg, ready_flag_next;
    logic                          enabled_flag_reg, enabled_flag_next;
    logic [hbpwm_pkg::DUTY_W-1:0]  duty_store_reg, duty_store_next;
    logic                          dir_store_reg, dir_store_next;
    logic                          en_store_reg, en_store_next;
    logic                          enb_store_reg, enb_store_next;
    logic [hbpwm_pkg::PERIOD_W-1:0] cmp1_store_reg, cmp1_store_next;
    logic [hbpwm_pkg::PERIOD_W-1:0] cmp2_store_reg, cmp2_store_next;

    logic                                   s1_valid_reg;
    logic [hbpwm_pkg::OP_W-1:0]             s1_op_reg;
    logic signed [hbpwm_pkg::DUTY_IN_W-1:0] s1_duty_reg;
    logic [hbpwm_pkg::DIR_IN_W-1:0]         s1_dir_reg;
    logic                                   s1_diag_reg;

    logic                           s2_valid_reg;
    hbpwm_pkg::status_t             s2_status_reg, s2_status_next;
    hbpwm_pkg::cmp_act_t            s2_act_reg, s2_act_next;
    logic [hbpwm_pkg::PROD_W-1:0]   s2_prod_reg, s2_prod_next;
    logic [hbpwm_pkg::PERIOD_W-1:0] s2_period_reg, s2_period_next;
    logic                           s2_fault_reg, s2_fault_next;

    logic                           out_valid_reg;
    hbpwm_pkg::status_t             out_status_reg;
    logic                           out_en_reg;
    logic                           out_enb_reg;
    logic                           out_fault_reg;
    logic                           out_is_en_reg;
    logic [hbpwm_pkg::DUTY_W-1:0]   out_duty_reg;
    logic                           out_dir_reg;

    logic out_adv, s2_adv, s1_adv, s1_fire, s2_fire;

    logic [hbpwm_pkg::DUTY_W-1:0]   duty_clamped;
    logic [hbpwm_pkg::MUL_W-1:0]    recip_prod;
    logic [hbpwm_pkg::QUOT_W-1:0]   quot;
    logic [hbpwm_pkg::PERIOD_W-1:0] cmp_value;

    assign out_adv = !out_valid_reg || rsp.ready;
    assign s2_adv  = !s2_valid_reg || out_adv;
    assign s1_adv  = !s1_valid_reg || s2_adv;
    assign s1_fire = s1_valid_reg && s2_adv;
    assign s2_fire = s2_valid_reg && out_adv;

    assign cmd.ready = s1_adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm1_period_reg <= hbpwm_pkg::PERIOD_RESET;
            pwm2_period_reg <= hbpwm_pkg::PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (hbpwm_pkg::cfg_index_t'(cfg.index))
                hbpwm_pkg::CFG_PWM1_PERIOD: pwm1_period_reg <= cfg.data;
                hbpwm_pkg::CFG_PWM2_PERIOD: pwm2_period_reg <= cfg.data;
                default:                    pwm1_period_reg <= pwm1_period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && cmd.valid)
        begin
            s1_op_reg   <= cmd.op;
            s1_duty_reg <= cmd.duty_request;
            s1_dir_reg  <= cmd.dir_request;
            s1_diag_reg <= cmd.diag_level;
        end
    end

    always_comb
    begin
        if (s1_duty_reg[hbpwm_pkg::DUTY_IN_W-1])
        begin
            duty_clamped = '0;
        end
        else if (s1_duty_reg[hbpwm_pkg::DUTY_IN_W-2:0] >
                 (hbpwm_pkg::DUTY_IN_W-1)'(hbpwm_pkg::DUTY_FULL))
        begin
            duty_clamped = hbpwm_pkg::DUTY_FULL;
        end
        else
        begin
            duty_clamped = s1_duty_reg[hbpwm_pkg::DUTY_W-1:0];
        end
    end

    always_comb
    begin
        ready_flag_next   = ready_flag_reg;
        enabled_flag_next = enabled_flag_reg;
        duty_store_next   = duty_store_reg;
        dir_store_next    = dir_store_reg;
        en_store_next     = en_store_reg;
        enb_store_next    = enb_store_reg;
        s2_status_next    = hbpwm_pkg::ST_OK;
        s2_act_next       = hbpwm_pkg::CMP_HOLD;

        unique case (hbpwm_pkg::op_t'(s1_op_reg)) inside
            hbpwm_pkg::OP_INIT:
            begin
                ready_flag_next   = 1'b1;
                enabled_flag_next = 1'b0;
                duty_store_next   = '0;
                dir_store_next    = 1'b0;
                en_store_next     = 1'b0;
                enb_store_next    = 1'b1;
                s2_act_next       = hbpwm_pkg::CMP_ZERO;
            end
            hbpwm_pkg::OP_DISABLE:
            begin
                if (ready_flag_reg)
                begin
                    enabled_flag_next = 1'b0;
                    duty_store_next   = '0;
                    en_store_next     = 1'b0;
                    enb_store_next    = 1'b1;
                    s2_act_next       = hbpwm_pkg::CMP_ZERO;
                end
            end
            hbpwm_pkg::OP_READ:
            begin
                s2_status_next = hbpwm_pkg::ST_OK;
            end
            hbpwm_pkg::OP_ENABLE, hbpwm_pkg::OP_SET_DUTY,
            hbpwm_pkg::OP_SET_DIR, hbpwm_pkg::OP_BRAKE:
            begin
                if (!ready_flag_reg)
                begin
                    s2_status_next = hbpwm_pkg::ST_NOT_INIT;
                end
                else
                begin
                    case (hbpwm_pkg::op_t'(s1_op_reg))
                        hbpwm_pkg::OP_ENABLE:
                        begin
                            enabled_flag_next = 1'b1;
                            en_store_next     = 1'b1;
                            enb_store_next    = 1'b0;
                            s2_act_next       = hbpwm_pkg::CMP_APPLY;
                        end
                        hbpwm_pkg::OP_SET_DUTY:
                        begin
                            duty_store_next = duty_clamped;
                            s2_act_next     = hbpwm_pkg::CMP_APPLY;
                        end
                        hbpwm_pkg::OP_SET_DIR:
                        begin
                            if (s1_dir_reg != hbpwm_pkg::DIR_FORWARD &&
                                s1_dir_reg != hbpwm_pkg::DIR_REVERSE)
                            begin
                                s2_status_next = hbpwm_pkg::ST_BAD_ARG;
                            end
                            else if (s1_dir_reg[0] != dir_store_reg)
                            begin
                                dir_store_next  = s1_dir_reg[0];
                                duty_store_next = '0;
                                s2_act_next     = hbpwm_pkg::CMP_ZERO;
                            end
                        end
                        default:
                        begin
                            enabled_flag_next = 1'b1;
                            duty_store_next   = '0;
                            en_store_next     = 1'b1;
                            enb_store_next    = 1'b0;
                            s2_act_next       = hbpwm_pkg::CMP_ZERO;
                        end
                    endcase
                end
            end
            default:
            begin
                s2_status_next = hbpwm_pkg::ST_BAD_ARG;
            end
        endcase

        // Outputs stay off unless the driver is ready, enabled and has a duty.
        if (s2_act_next == hbpwm_pkg::CMP_APPLY &&
            (!ready_flag_next || !enabled_flag_next || duty_store_next == '0))
        begin
            s2_act_next = hbpwm_pkg::CMP_ZERO;
        end

        s2_period_next = dir_store_next ? pwm2_period_reg : pwm1_period_reg;
        s2_prod_next   = hbpwm_pkg::PROD_W'(s2_period_next) *
                         hbpwm_pkg::PROD_W'(duty_store_next);
        s2_fault_next  = ready_flag_next && enabled_flag_next && !s1_diag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_flag_reg   <= 1'b0;
            enabled_flag_reg <= 1'b0;
            duty_store_reg   <= '0;
            dir_store_reg    <= 1'b0;
            en_store_reg     <= 1'b0;
            enb_store_reg    <= 1'b1;
        end
        else if (s1_fire)
        begin
            ready_flag_reg   <= ready_flag_next;
            enabled_flag_reg <= enabled_flag_next;
            duty_store_reg   <= duty_store_next;
            dir_store_reg    <= dir_store_next;
            en_store_reg     <= en_store_next;
            enb_store_reg    <= enb_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_status_reg <= s2_status_next;
            s2_act_reg    <= s2_act_next;
            s2_prod_reg   <= s2_prod_next;
            s2_period_reg <= s2_period_next;
            s2_fault_reg  <= s2_fault_next;
        end
    end

    // Second stage: the compare value, with the stored state already updated.
    always_comb
    begin
        recip_prod = hbpwm_pkg::MUL_W'(s2_prod_reg[hbpwm_pkg::PROD_W-1:hbpwm_pkg::PRE_SHIFT]) *
                     hbpwm_pkg::MUL_W'(hbpwm_pkg::RECIP_625);
        quot       = recip_prod[hbpwm_pkg::MUL_W-1:hbpwm_pkg::RECIP_SHIFT];
        if (quot > hbpwm_pkg::QUOT_W'(s2_period_reg))
        begin
            cmp_value = s2_period_reg;
        end
        else
        begin
            cmp_value = quot[hbpwm_pkg::PERIOD_W-1:0];
        end

        cmp1_store_next = cmp1_store_reg;
        cmp2_store_next = cmp2_store_reg;
        case (s2_act_reg)
            hbpwm_pkg::CMP_ZERO:
            begin
                cmp1_store_next = '0;
                cmp2_store_next = '0;
            end
            hbpwm_pkg::CMP_APPLY:
            begin
                cmp1_store_next = dir_store_reg ? '0 : cmp_value;
                cmp2_store_next = dir_store_reg ? cmp_value : '0;
            end
            default:
            begin
                cmp1_store_next = cmp1_store_reg;
                cmp2_store_next = cmp2_store_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp1_store_reg <= '0;
            cmp2_store_reg <= '0;
        end
        else if (s2_fire)
        begin
            cmp1_store_reg <= cmp1_store_next;
            cmp2_store_reg <= cmp2_store_next;
        end
    end

    // The stage-two copies of the flags are taken from the next values of the state registers,
    // which an item updates as it leaves stage one.
    logic                          s2_en_reg, s2_enb_reg, s2_is_en_reg, s2_dir_reg;
    logic [hbpwm_pkg::DUTY_W-1:0]  s2_duty_reg;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_en_reg    <= en_store_next;
            s2_enb_reg   <= enb_store_next;
            s2_is_en_reg <= ready_flag_next && enabled_flag_next;
            s2_dir_reg   <= dir_store_next;
            s2_duty_reg  <= duty_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            out_status_reg <= s2_status_reg;
            out_en_reg     <= s2_en_reg;
            out_enb_reg    <= s2_enb_reg;
            out_fault_reg  <= s2_fault_reg;
            out_is_en_reg  <= s2_is_en_reg;
            out_duty_reg   <= s2_duty_reg;
            out_dir_reg    <= s2_dir_reg;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.pwm1_compare     = cmp1_store_reg;
    assign rsp.pwm2_compare     = cmp2_store_reg;
    assign rsp.enable_level     = out_en_reg;
    assign rsp.enable_bar_level = out_enb_reg;
    assign rsp.fault            = out_fault_reg;
    assign rsp.is_enabled       = out_is_en_reg;
    assign rsp.duty_now         = out_duty_reg;
    assign rsp.dir_now          = out_dir_reg;

endmodule

/* sv/hbpwm_checker.sv */
`timescale 1ns / 1ps
`include "h_bridge_pwm_command_unit_defines.svh"

module hbpwm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [hbpwm_pkg::STATUS_W-1:0]     rsp_status,
    input logic [hbpwm_pkg::PERIOD_W-1:0]     rsp_pwm1_compare,
    input logic [hbpwm_pkg::PERIOD_W-1:0]     rsp_pwm2_compare,
    input logic                               rsp_enable_level,
    input logic                               rsp_enable_bar_level,
    input logic                               rsp_fault,
    input logic                               rsp_is_enabled,
    input logic [hbpwm_pkg::DUTY_W-1:0]       rsp_duty_now,
    input logic                               rsp_dir_now
);

    // A stalled response item must not change.
    `HBPWM_ASSERT_NEXT(a_rsp_hold, clk, rst_n,
        rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status) && $stable(rsp_pwm1_compare)
            && $stable(rsp_pwm2_compare) && $stable(rsp_duty_now) && $stable(rsp_dir_now),
        "response changed while stalled")

    // EN and ENB are always complementary and EN follows the enable state.
    `HBPWM_ASSERT_NOW(a_en_pair, clk, rst_n,
        rsp_valid,
        rsp_enable_level != rsp_enable_bar_level && rsp_enable_level == rsp_is_enabled,
        "EN/ENB inconsistent with enable state")

    // A running channel needs an enabled driver, a duty and the matching direction.
    `HBPWM_ASSERT_NOW(a_cmp_drive, clk, rst_n,
        rsp_valid && (rsp_pwm1_compare != '0 || rsp_pwm2_compare != '0),
        rsp_is_enabled && rsp_duty_now != '0
            && (rsp_pwm1_compare == '0 || rsp_pwm2_compare == '0)
            && (rsp_pwm1_compare == '0 || !rsp_dir_now)
            && (rsp_pwm2_compare == '0 || rsp_dir_now),
        "compare driven in an invalid state")

    // A fault is only reported while the driver is enabled.
    `HBPWM_ASSERT_NOW(a_fault_en, clk, rst_n,
        rsp_valid && rsp_fault,
        rsp_is_enabled,
        "fault reported while disabled")

endmodule

bind h_bridge_pwm_command_unit hbpwm_checker u_hbpwm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .rsp_valid            (rsp.valid),
    .rsp_ready            (rsp.ready),
    .rsp_status           (rsp.status),
    .rsp_pwm1_compare     (rsp.pwm1_compare),
    .rsp_pwm2_compare     (rsp.pwm2_compare),
    .rsp_enable_level     (rsp.enable_level),
    .rsp_enable_bar_level (rsp.enable_bar_level),
    .rsp_fault            (rsp.fault),
    .rsp_is_enabled       (rsp.is_enabled),
    .rsp_duty_now         (rsp.duty_now),
    .rsp_dir_now          (rsp.dir_now)
);
